// ----- rtl/rrss_pkg.sv -----
// ----------------------------------------------------------------------------
// rrss_pkg
// Shared types and constants for the round-robin slice scheduler: payload
// structs, job table entry, result and opcode codes, controller interface.
// ----------------------------------------------------------------------------
`default_nettype none

package rrss_pkg;

   localparam int ARR_W     = 16;
   localparam int BURST_W   = 16;
   localparam int QUANTUM_W = 16;
   localparam int OUT_T_W   = 24;
   localparam int OUT_IDX_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] QUANTUM_RESET = 16'd4;
   localparam logic [1:0]  LAST_ATTEMPT  = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_STEP  = 2'd2,
      OP_NOP   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SLICE = 2'd0,
      KIND_IDLE  = 2'd1,
      KIND_DONE  = 2'd2,
      KIND_FULL  = 2'd3
   } kind_type;

   typedef struct packed {
      opcode_type           opcode;
      logic [ARR_W-1:0]     arrival_time;
      logic [BURST_W-1:0]   burst_time;
   } req_type;

   typedef struct packed {
      kind_type               kind;
      logic [OUT_IDX_W-1:0]   job_index;
      logic [OUT_T_W-1:0]     start_time;
      logic [OUT_T_W-1:0]     end_time;
      logic                   finished;
      logic [OUT_T_W-1:0]     turnaround;
      logic [OUT_T_W-1:0]     waiting;
   } rsp_type;

   typedef struct packed {
      logic [ARR_W-1:0]     arrival;
      logic [BURST_W-1:0]   burst;
      logic [BURST_W-1:0]   remaining;
   } job_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN_RD,
      ST_SCAN_EV,
      ST_PASS_END,
      ST_MIN_RD,
      ST_MIN_EV,
      ST_MIN_END,
      ST_TAT,
      ST_WT,
      ST_EMIT
   } ctrl_state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_ACCEPT,
      DP_CLEAR,
      DP_LOAD,
      DP_FULL,
      DP_DONE,
      DP_START,
      DP_ADVANCE,
      DP_RUN,
      DP_NEXT_ATTEMPT,
      DP_MIN_START,
      DP_MIN_STEP,
      DP_IDLE_GAP,
      DP_FALLBACK,
      DP_TAT,
      DP_WT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      push;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       table_full;
      logic       all_done;
      logic       cursor_end;
      logic       eligible;
      logic       slice_finishes;
      logic       pass_found;
      logic       last_attempt;
      logic       gap_ready;
      logic       out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- rtl/rrss_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrss_ctrl
// Sequencer for the scheduler: decodes each request beat and walks the job
// table scan, the minimum-arrival scan and the finish arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module rrss_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  rrss_pkg::dp_status_type status,
   output rrss_pkg::dp_cmd_type   cmd
);

   rrss_pkg::ctrl_state_type state_ff;
   rrss_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = rrss_pkg::DP_NOP;
      cmd.push  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         rrss_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = rrss_pkg::DP_ACCEPT;
               state_in = rrss_pkg::ST_DISPATCH;
            end
         end
         rrss_pkg::ST_DISPATCH: begin
            unique case (status.opcode)
               rrss_pkg::OP_CLEAR: begin
                  cmd.op   = rrss_pkg::DP_CLEAR;
                  state_in = rrss_pkg::ST_IDLE;
               end
               rrss_pkg::OP_LOAD: begin
                  if (status.table_full) begin
                     cmd.op   = rrss_pkg::DP_FULL;
                     state_in = rrss_pkg::ST_EMIT;
                  end else begin
                     cmd.op   = rrss_pkg::DP_LOAD;
                     state_in = rrss_pkg::ST_IDLE;
                  end
               end
               rrss_pkg::OP_STEP: begin
                  if (status.all_done) begin
                     cmd.op   = rrss_pkg::DP_DONE;
                     state_in = rrss_pkg::ST_EMIT;
                  end else begin
                     cmd.op   = rrss_pkg::DP_START;
                     state_in = rrss_pkg::ST_SCAN_RD;
                  end
               end
               rrss_pkg::OP_NOP: begin
                  state_in = rrss_pkg::ST_IDLE;
               end
            endcase
         end
         rrss_pkg::ST_SCAN_RD: begin
            state_in = status.cursor_end ? rrss_pkg::ST_PASS_END : rrss_pkg::ST_SCAN_EV;
         end
         rrss_pkg::ST_SCAN_EV: begin
            if (status.eligible) begin
               cmd.op   = rrss_pkg::DP_RUN;
               state_in = status.slice_finishes ? rrss_pkg::ST_TAT : rrss_pkg::ST_EMIT;
            end else begin
               cmd.op   = rrss_pkg::DP_ADVANCE;
               state_in = rrss_pkg::ST_SCAN_RD;
            end
         end
         rrss_pkg::ST_PASS_END: begin
            priority if (!status.pass_found) begin
               cmd.op   = rrss_pkg::DP_MIN_START;
               state_in = rrss_pkg::ST_MIN_RD;
            end else if (status.last_attempt) begin
               cmd.op   = rrss_pkg::DP_FALLBACK;
               state_in = rrss_pkg::ST_EMIT;
            end else begin
               cmd.op   = rrss_pkg::DP_NEXT_ATTEMPT;
               state_in = rrss_pkg::ST_SCAN_RD;
            end
         end
         rrss_pkg::ST_MIN_RD: begin
            state_in = status.cursor_end ? rrss_pkg::ST_MIN_END : rrss_pkg::ST_MIN_EV;
         end
         rrss_pkg::ST_MIN_EV: begin
            cmd.op   = rrss_pkg::DP_MIN_STEP;
            state_in = rrss_pkg::ST_MIN_RD;
         end
         rrss_pkg::ST_MIN_END: begin
            priority if (status.gap_ready) begin
               cmd.op   = rrss_pkg::DP_IDLE_GAP;
               state_in = rrss_pkg::ST_EMIT;
            end else if (status.last_attempt) begin
               cmd.op   = rrss_pkg::DP_FALLBACK;
               state_in = rrss_pkg::ST_EMIT;
            end else begin
               cmd.op   = rrss_pkg::DP_NEXT_ATTEMPT;
               state_in = rrss_pkg::ST_SCAN_RD;
            end
         end
         rrss_pkg::ST_TAT: begin
            cmd.op   = rrss_pkg::DP_TAT;
            state_in = rrss_pkg::ST_WT;
         end
         rrss_pkg::ST_WT: begin
            cmd.op   = rrss_pkg::DP_WT;
            state_in = rrss_pkg::ST_EMIT;
         end
         rrss_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = rrss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrss_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/rrss_datapath.sv -----
// ----------------------------------------------------------------------------
// rrss_datapath
// Job table memory, scan cursor, simulated time, counters, result staging and
// the output register of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

module rrss_datapath #(
   parameter int MAX_PROCESSES = 16,
   parameter int TIME_WIDTH    = 24
) (
   input  wire                          clock,
   input  wire                          reset,
   input  rrss_pkg::req_type            req_data,
   input  wire [rrss_pkg::QUANTUM_W-1:0] quantum,
   input  rrss_pkg::dp_cmd_type         cmd,
   output rrss_pkg::dp_status_type      status,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output rrss_pkg::rsp_type            rsp_data
);

   localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CW = $clog2(MAX_PROCESSES + 1);
   localparam int TW = TIME_WIDTH;
   localparam int OW = rrss_pkg::OUT_T_W;
   localparam int XW = TW - rrss_pkg::ARR_W;

   rrss_pkg::job_entry_type job_mem [MAX_PROCESSES];
   rrss_pkg::job_entry_type job_rd_ff;

   logic                    mem_we;
   logic [IW-1:0]           mem_waddr;
   rrss_pkg::job_entry_type mem_wdata;

   rrss_pkg::req_type req_ff, req_in;

   logic [CW-1:0] job_count_ff, job_count_in;
   logic [CW-1:0] finished_count_ff, finished_count_in;
   logic [TW-1:0] time_ff, time_in;
   logic [CW-1:0] scan_pos_ff, scan_pos_in;
   logic          pass_found_ff, pass_found_in;
   logic [CW-1:0] cursor_ff, cursor_in;
   logic [1:0]    attempt_ff, attempt_in;
   logic [rrss_pkg::ARR_W-1:0] min_arr_ff, min_arr_in;
   logic          have_min_ff, have_min_in;

   rrss_pkg::kind_type res_kind_ff, res_kind_in;
   logic [IW-1:0] res_index_ff, res_index_in;
   logic [TW-1:0] res_start_ff, res_start_in;
   logic [TW-1:0] res_end_ff, res_end_in;
   logic          res_fin_ff, res_fin_in;
   logic [TW-1:0] res_tat_ff, res_tat_in;
   logic [TW-1:0] res_wt_ff, res_wt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rrss_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [rrss_pkg::QUANTUM_W-1:0] q_eff;
   logic                           slice_done;
   logic [rrss_pkg::BURST_W-1:0]   slice_len;
   logic [TW:0]                    slice_sum;
   logic [TW-1:0]                  slice_end;
   logic [TW-1:0]                  rd_arr_ext;
   logic [TW-1:0]                  rd_burst_ext;
   logic [TW-1:0]                  min_arr_ext;
   logic [TW:0]                    wt_diff;
   logic                           out_free;

   logic [TW+OW-1:0]   start_wide, end_wide, tat_wide, wt_wide;
   logic [IW+rrss_pkg::OUT_IDX_W-1:0] index_wide;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[mem_waddr] <= mem_wdata;
      end
      job_rd_ff <= job_mem[cursor_ff[IW-1:0]];
   end

   assign q_eff        = (quantum == '0) ? rrss_pkg::QUANTUM_W'(1) : quantum;
   assign slice_done   = job_rd_ff.remaining <= q_eff;
   assign slice_len    = slice_done ? job_rd_ff.remaining : q_eff;
   assign slice_sum    = {1'b0, time_ff} + {{(TW + 1 - rrss_pkg::BURST_W){1'b0}}, slice_len};
   assign slice_end    = slice_sum[TW] ? {TW{1'b1}} : slice_sum[TW-1:0];
   assign rd_arr_ext   = {{XW{1'b0}}, job_rd_ff.arrival};
   assign rd_burst_ext = {{XW{1'b0}}, job_rd_ff.burst};
   assign min_arr_ext  = {{XW{1'b0}}, min_arr_ff};
   assign wt_diff      = {1'b0, res_tat_ff} - {1'b0, rd_burst_ext};
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   assign status.opcode         = req_ff.opcode;
   assign status.table_full     = job_count_ff == CW'(MAX_PROCESSES);
   assign status.all_done       = finished_count_ff >= job_count_ff;
   assign status.cursor_end     = cursor_ff >= job_count_ff;
   assign status.eligible       = (job_rd_ff.remaining != '0) && (rd_arr_ext <= time_ff);
   assign status.slice_finishes = slice_done;
   assign status.pass_found     = pass_found_ff;
   assign status.last_attempt   = attempt_ff == rrss_pkg::LAST_ATTEMPT;
   assign status.gap_ready      = have_min_ff && (time_ff < min_arr_ext);
   assign status.out_free       = out_free;

   always_comb begin
      req_in            = req_ff;
      job_count_in      = job_count_ff;
      finished_count_in = finished_count_ff;
      time_in           = time_ff;
      scan_pos_in       = scan_pos_ff;
      pass_found_in     = pass_found_ff;
      cursor_in         = cursor_ff;
      attempt_in        = attempt_ff;
      min_arr_in        = min_arr_ff;
      have_min_in       = have_min_ff;
      res_kind_in       = res_kind_ff;
      res_index_in      = res_index_ff;
      res_start_in      = res_start_ff;
      res_end_in        = res_end_ff;
      res_fin_in        = res_fin_ff;
      res_tat_in        = res_tat_ff;
      res_wt_in         = res_wt_ff;
      mem_we            = 1'b0;
      mem_waddr         = cursor_ff[IW-1:0];
      mem_wdata         = job_rd_ff;
      unique case (cmd.op)
         rrss_pkg::DP_NOP: begin
         end
         rrss_pkg::DP_ACCEPT: begin
            req_in = req_data;
         end
         rrss_pkg::DP_CLEAR: begin
            job_count_in      = '0;
            finished_count_in = '0;
            time_in           = '0;
            scan_pos_in       = '0;
            pass_found_in     = 1'b0;
         end
         rrss_pkg::DP_LOAD: begin
            mem_we              = 1'b1;
            mem_waddr           = job_count_ff[IW-1:0];
            mem_wdata.arrival   = req_ff.arrival_time;
            mem_wdata.burst     = req_ff.burst_time;
            mem_wdata.remaining = req_ff.burst_time;
            job_count_in        = job_count_ff + CW'(1);
            if (req_ff.burst_time == '0) begin
               finished_count_in = finished_count_ff + CW'(1);
            end
         end
         rrss_pkg::DP_FULL: begin
            res_kind_in  = rrss_pkg::KIND_FULL;
            res_index_in = '0;
            res_start_in = '0;
            res_end_in   = '0;
            res_fin_in   = 1'b0;
            res_tat_in   = '0;
            res_wt_in    = '0;
         end
         rrss_pkg::DP_DONE, rrss_pkg::DP_FALLBACK: begin
            res_kind_in  = (cmd.op == rrss_pkg::DP_DONE) ? rrss_pkg::KIND_DONE
                                                         : rrss_pkg::KIND_IDLE;
            res_index_in = '0;
            res_start_in = time_ff;
            res_end_in   = time_ff;
            res_fin_in   = 1'b0;
            res_tat_in   = '0;
            res_wt_in    = '0;
         end
         rrss_pkg::DP_START: begin
            cursor_in  = scan_pos_ff;
            attempt_in = '0;
         end
         rrss_pkg::DP_ADVANCE: begin
            cursor_in = cursor_ff + CW'(1);
         end
         rrss_pkg::DP_RUN: begin
            mem_we              = 1'b1;
            mem_wdata.remaining = slice_done ? '0 : job_rd_ff.remaining - q_eff;
            time_in             = slice_end;
            scan_pos_in         = cursor_ff + CW'(1);
            pass_found_in       = 1'b1;
            if (slice_done) begin
               finished_count_in = finished_count_ff + CW'(1);
            end
            res_kind_in  = rrss_pkg::KIND_SLICE;
            res_index_in = cursor_ff[IW-1:0];
            res_start_in = time_ff;
            res_end_in   = slice_end;
            res_fin_in   = slice_done;
            res_tat_in   = '0;
            res_wt_in    = '0;
         end
         rrss_pkg::DP_NEXT_ATTEMPT: begin
            scan_pos_in   = '0;
            pass_found_in = 1'b0;
            cursor_in     = '0;
            attempt_in    = attempt_ff + 2'd1;
         end
         rrss_pkg::DP_MIN_START: begin
            scan_pos_in = '0;
            cursor_in   = '0;
            have_min_in = 1'b0;
         end
         rrss_pkg::DP_MIN_STEP: begin
            if ((job_rd_ff.remaining != '0)
                  && (!have_min_ff || (job_rd_ff.arrival < min_arr_ff))) begin
               min_arr_in  = job_rd_ff.arrival;
               have_min_in = 1'b1;
            end
            cursor_in = cursor_ff + CW'(1);
         end
         rrss_pkg::DP_IDLE_GAP: begin
            time_in      = min_arr_ext;
            res_kind_in  = rrss_pkg::KIND_IDLE;
            res_index_in = '0;
            res_start_in = time_ff;
            res_end_in   = min_arr_ext;
            res_fin_in   = 1'b0;
            res_tat_in   = '0;
            res_wt_in    = '0;
         end
         rrss_pkg::DP_TAT: begin
            res_tat_in = res_end_ff - rd_arr_ext;
         end
         rrss_pkg::DP_WT: begin
            res_wt_in = wt_diff[TW] ? '0 : wt_diff[TW-1:0];
         end
      endcase
   end

   assign start_wide = {{OW{1'b0}}, res_start_ff};
   assign end_wide   = {{OW{1'b0}}, res_end_ff};
   assign tat_wide   = {{OW{1'b0}}, res_tat_ff};
   assign wt_wide    = {{OW{1'b0}}, res_wt_ff};
   assign index_wide = {{rrss_pkg::OUT_IDX_W{1'b0}}, res_index_ff};

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.push) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.kind       = res_kind_ff;
         rsp_data_in.job_index  = index_wide[rrss_pkg::OUT_IDX_W-1:0];
         rsp_data_in.start_time = start_wide[OW-1:0];
         rsp_data_in.end_time   = end_wide[OW-1:0];
         rsp_data_in.finished   = res_fin_ff;
         rsp_data_in.turnaround = tat_wide[OW-1:0];
         rsp_data_in.waiting    = wt_wide[OW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff      <= '0;
         finished_count_ff <= '0;
         time_ff           <= '0;
         scan_pos_ff       <= '0;
         pass_found_ff     <= 1'b0;
         cursor_ff         <= '0;
         attempt_ff        <= '0;
         have_min_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         job_count_ff      <= job_count_in;
         finished_count_ff <= finished_count_in;
         time_ff           <= time_in;
         scan_pos_ff       <= scan_pos_in;
         pass_found_ff     <= pass_found_in;
         cursor_ff         <= cursor_in;
         attempt_ff        <= attempt_in;
         have_min_ff       <= have_min_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      min_arr_ff   <= min_arr_in;
      res_kind_ff  <= res_kind_in;
      res_index_ff <= res_index_in;
      res_start_ff <= res_start_in;
      res_end_ff   <= res_end_in;
      res_fin_ff   <= res_fin_in;
      res_tat_ff   <= res_tat_in;
      res_wt_ff    <= res_wt_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- rtl/round_robin_slice_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_slice_scheduler
// Clear, load and no-op beats return to idle without a result; a rejected load
// emits a full result. A step scans the job table from the scan position and,
// if a pass finds nothing, runs a minimum-arrival pass (up to three attempts
// of scan and minimum-arrival passes), then computes turnaround and waiting
// for a finishing slice. The result is registered onto rsp, one beat at a time;
// a stalled result holds off the next result beat.
// Reset clears counts, time and scan and sets quantum (4); the job table is not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_slice_scheduler #(
   parameter int MAX_PROCESSES = 16,
   parameter int TIME_WIDTH    = 24
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  rrss_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output rrss_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [rrss_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  wire [rrss_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [rrss_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [rrss_pkg::QUANTUM_W-1:0] quantum_ff, quantum_in;
   logic                           quantum_sel;

   rrss_pkg::dp_cmd_type    cmd;
   rrss_pkg::dp_status_type status;

   assign quantum_sel = csr_paddr[rrss_pkg::CSR_ADDR_W-1] == 1'b0;
   assign csr_pready  = 1'b1;
   assign quantum_in  = (csr_psel && csr_penable && csr_pwrite && quantum_sel)
                      ? csr_pwdata[rrss_pkg::QUANTUM_W-1:0] : quantum_ff;
   assign csr_prdata  = quantum_sel
                      ? {{(rrss_pkg::CSR_DATA_W - rrss_pkg::QUANTUM_W){1'b0}}, quantum_ff}
                      : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrss_pkg::QUANTUM_RESET;
      end else begin
         quantum_ff <= quantum_in;
      end
   end

   rrss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rrss_datapath #(
      .MAX_PROCESSES (MAX_PROCESSES),
      .TIME_WIDTH    (TIME_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .quantum   (quantum_ff),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
